>>> rtl/fru_pkg.sv
// ----------------------------------------------------------------------------
// fru_pkg
// Shared widths, constants and the sideband type of the reflectance pipeline.
// ----------------------------------------------------------------------------
package fru_pkg;

  // vector format
  localparam int VEC_W         = 16;
  localparam int VEC_FRAC_BITS = 14;
  localparam int PROD_W        = 2 * VEC_W;
  localparam int DOT_W         = PROD_W + 2;

  // alignment of the dot product magnitude to Q1.30
  localparam int MAG_SH_L = (2 * VEC_FRAC_BITS < 30) ? (30 - 2 * VEC_FRAC_BITS) : 0;
  localparam int MAG_SH_R = (2 * VEC_FRAC_BITS >= 30) ? (2 * VEC_FRAC_BITS - 30) : 0;
  localparam int SHIFT_W  = DOT_W + MAG_SH_L;

  // index format
  localparam int IDX_W = 14;
  localparam logic [IDX_W-1:0] IDX_ONE    = IDX_W'(4096);
  localparam logic [IDX_W-1:0] IDX_RESET  = IDX_W'(6144);

  // Q1.30 cosine / sine values and their Q1.60 squares
  localparam int MAG_W  = 31;
  localparam int RAD_W  = 61;
  localparam int ROOT_W = 31;
  localparam logic [MAG_W-1:0] ONE_Q30 = MAG_W'(64'd1 << 30);
  localparam logic [RAD_W-1:0] ONE_Q60 = RAD_W'(64'd1 << 60);

  // snell divider: quotient bits below one
  localparam int SN_NUM_W = ROOT_W + IDX_W;
  localparam int SN_Q_W   = 30;

  // amplitude ratio divider
  localparam int RR_NUM_W  = MAG_W + IDX_W + 1;
  localparam int RR_FRAC   = 16;
  localparam int RR_Q_W    = RR_FRAC + 1;
  localparam int RR_REM_W  = RR_NUM_W + RR_FRAC;

  // output format
  localparam int OUT_W = 16;
  localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(32768);

  // sideband carried along the long arithmetic pipes
  typedef struct packed {
    logic             tir;
    logic [MAG_W-1:0] mag;
    logic [IDX_W-1:0] etai;
    logic [IDX_W-1:0] etat;
  } side_t;

endpackage

>>> rtl/fru_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// fru_sqrt_pipe
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module fru_sqrt_pipe (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [fru_pkg::RAD_W-1:0]  rad_i,
  input  fru_pkg::side_t             side_i,
  output logic                       vld_o,
  output logic [fru_pkg::ROOT_W-1:0] root_o,
  output fru_pkg::side_t             side_o
);
  import fru_pkg::*;

  logic              vld_q  [ROOT_W];
  logic [RAD_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  side_t             side_q [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;
    logic              vld_in;
    logic [RAD_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic [RAD_W+1:0]  trial;

    if (j == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    // trial subtrahend (2r + 2^k) * 2^k for root bit k
    assign trial = ((RAD_W+2)'(root_in) << (K + 1)) + ((RAD_W+2)'(1) << (2 * K));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= side_in;
        if ((RAD_W+2)'(rem_in) >= trial) begin
          rem_q[j]  <= rem_in - trial[RAD_W-1:0];
          root_q[j] <= root_in | (ROOT_W'(1) << K);
        end else begin
          rem_q[j]  <= rem_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

>>> rtl/fru_snell_div.sv
// ----------------------------------------------------------------------------
// fru_snell_div
// Pipelined restoring divider for the transmitted sine, with an up-front
// check for total internal reflection (quotient at or above one).
// ----------------------------------------------------------------------------
module fru_snell_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [fru_pkg::SN_NUM_W-1:0] num_i,
  input  fru_pkg::side_t               side_i,
  output logic                         vld_o,
  output logic [fru_pkg::SN_Q_W-1:0]   quot_o,
  output fru_pkg::side_t               side_o
);
  import fru_pkg::*;

  localparam int NST = SN_Q_W + 1;

  logic                vld_q  [NST];
  logic [SN_NUM_W-1:0] rem_q  [NST];
  logic [SN_Q_W-1:0]   quot_q [NST];
  side_t               side_q [NST];
  side_t               side_first_d;

  // first stage: quotient reaches one when num >= etat * 2^30
  always_comb begin
    side_first_d     = side_i;
    side_first_d.tir = num_i >= (SN_NUM_W'(side_i.etat) << SN_Q_W);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_first_d;
      rem_q[0]  <= num_i;
      quot_q[0] <= '0;
    end
  end

  // one quotient bit per stage
  for (genvar j = 1; j < NST; j++) begin : g_stage
    localparam int K = SN_Q_W - j;
    logic [SN_NUM_W-1:0] trial;

    assign trial = SN_NUM_W'(side_q[j-1].etat) << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= side_q[j-1];
        if (rem_q[j-1] >= trial) begin
          rem_q[j]  <= rem_q[j-1] - trial;
          quot_q[j] <= quot_q[j-1] | (SN_Q_W'(1) << K);
        end else begin
          rem_q[j]  <= rem_q[j-1];
          quot_q[j] <= quot_q[j-1];
        end
      end
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign quot_o = quot_q[NST-1];
  assign side_o = side_q[NST-1];

endmodule

>>> rtl/fru_ratio_div.sv
// ----------------------------------------------------------------------------
// fru_ratio_div
// Two-lane pipelined restoring divider for the s and p amplitude ratios,
// num * 2^16 / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fru_ratio_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [fru_pkg::RR_NUM_W-1:0] num_s_i,
  input  logic [fru_pkg::RR_NUM_W-1:0] den_s_i,
  input  logic [fru_pkg::RR_NUM_W-1:0] num_p_i,
  input  logic [fru_pkg::RR_NUM_W-1:0] den_p_i,
  input  logic                         tir_i,
  output logic                         vld_o,
  output logic [fru_pkg::RR_Q_W-1:0]   quot_s_o,
  output logic [fru_pkg::RR_Q_W-1:0]   quot_p_o,
  output logic                         tir_o
);
  import fru_pkg::*;

  logic                vld_q  [RR_Q_W];
  logic                tir_q  [RR_Q_W];
  logic [RR_REM_W-1:0] rem_q  [RR_Q_W][2];
  logic [RR_NUM_W-1:0] den_q  [RR_Q_W][2];
  logic [RR_Q_W-1:0]   quot_q [RR_Q_W][2];

  for (genvar j = 0; j < RR_Q_W; j++) begin : g_stage
    localparam int K = RR_Q_W - 1 - j;
    logic                vld_in;
    logic                tir_in;
    logic [RR_REM_W-1:0] rem_in  [2];
    logic [RR_NUM_W-1:0] den_in  [2];
    logic [RR_Q_W-1:0]   quot_in [2];

    if (j == 0) begin : g_first
      assign vld_in     = vld_i;
      assign tir_in     = tir_i;
      assign rem_in[0]  = RR_REM_W'(num_s_i) << RR_FRAC;
      assign rem_in[1]  = RR_REM_W'(num_p_i) << RR_FRAC;
      assign den_in[0]  = den_s_i;
      assign den_in[1]  = den_p_i;
      assign quot_in[0] = '0;
      assign quot_in[1] = '0;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign tir_in  = tir_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign den_in  = den_q[j-1];
      assign quot_in = quot_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    // both lanes step together
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tir_q[j] <= tir_in;
        for (int l = 0; l < 2; l++) begin
          den_q[j][l] <= den_in[l];
          if (rem_in[l] >= (RR_REM_W'(den_in[l]) << K)) begin
            rem_q[j][l]  <= rem_in[l] - (RR_REM_W'(den_in[l]) << K);
            quot_q[j][l] <= quot_in[l] | (RR_Q_W'(1) << K);
          end else begin
            rem_q[j][l]  <= rem_in[l];
            quot_q[j][l] <= quot_in[l];
          end
        end
      end
    end
  end

  assign vld_o    = vld_q[RR_Q_W-1];
  assign tir_o    = tir_q[RR_Q_W-1];
  assign quot_s_o = quot_q[RR_Q_W-1][0];
  assign quot_p_o = quot_q[RR_Q_W-1][1];

endmodule

>>> rtl/fresnel_reflectance_unit.sv
// ----------------------------------------------------------------------------
// fresnel_reflectance_unit
// Unpolarized Fresnel reflectance of a dielectric, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one word: incident and
//   normal vectors in Q1.14. Output channel out_valid_o / out_stall_i carries
//   the Q1.15 reflectance and the total internal reflection flag.
//   The refractive index (Q2.12) is written through cfg_we_i / cfg_wdata_i
//   while the unit is idle; it resets to 1.5.
//   The pipeline has 122 register stages and takes one word per cycle while
//   in_stall_o is low. The stages come from three bit-per-stage units:
//   two 31-stage square roots and a 31-stage snell divider, plus a 17-stage
//   two-lane ratio divider and the multiply stages around them.
//   All stages move on one shared enable that drops only while the output
//   register holds a word and out_stall_i is high; then in_stall_o is high
//   and nothing is lost or repeated. Bubbles are carried as invalid stages.
//   Reset clears all valid bits; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
module fresnel_reflectance_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fru_pkg::IDX_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [fru_pkg::VEC_W-1:0] incident_x_i,
  input  logic signed [fru_pkg::VEC_W-1:0] incident_y_i,
  input  logic signed [fru_pkg::VEC_W-1:0] incident_z_i,
  input  logic signed [fru_pkg::VEC_W-1:0] normal_x_i,
  input  logic signed [fru_pkg::VEC_W-1:0] normal_y_i,
  input  logic signed [fru_pkg::VEC_W-1:0] normal_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fru_pkg::OUT_W-1:0]       reflectance_o,
  output logic                            total_internal_o
);
  import fru_pkg::*;

  logic en;
  logic [IDX_W-1:0] index_q;

  // refractive index register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= IDX_RESET;
    end else if (cfg_we_i) begin
      index_q <= cfg_wdata_i;
    end
  end

  // shared pipeline enable
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // valid bits of the front and back stages
  logic v_prod_q, v_dot_q, v_mag_q, v_sq_q, v_rad_q;
  logic v_num_q, v_sq2_q, v_rad2_q, v_ab_q, v_nd_q, v_rsq_q, v_out_q;
  logic v_sqrt1, v_snell, v_sqrt2, v_ratio;

  // stage: component products
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  // stage: dot product
  logic signed [DOT_W-1:0]  dot_q;
  // stage: clamped magnitude and index selection
  side_t                    side_mag_q;
  // stage: magnitude squared
  logic [2*MAG_W-1:0]       sq_q;
  side_t                    side_sq_q;
  // stage: 1 - c^2
  logic [RAD_W-1:0]         rad_q;
  side_t                    side_rad_q;

  logic [DOT_W-1:0]   dot_abs;
  logic [SHIFT_W-1:0] mag_sh;
  logic [IDX_W-1:0]   idx_eff;
  side_t              side_mag_d;

  assign dot_abs = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
  assign mag_sh  = (SHIFT_W'(dot_abs) >> MAG_SH_R) << MAG_SH_L;
  assign idx_eff = (index_q == '0) ? IDX_W'(1) : index_q;

  always_comb begin
    side_mag_d     = '0;
    side_mag_d.mag = (mag_sh > SHIFT_W'(ONE_Q30)) ? ONE_Q30 : mag_sh[MAG_W-1:0];
    // leaving the material when the dot product is strictly positive
    if (!dot_q[DOT_W-1] && (dot_q != '0)) begin
      side_mag_d.etai = idx_eff;
      side_mag_d.etat = IDX_ONE;
    end else begin
      side_mag_d.etai = IDX_ONE;
      side_mag_d.etat = idx_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_prod_q <= 1'b0;
      v_dot_q  <= 1'b0;
      v_mag_q  <= 1'b0;
      v_sq_q   <= 1'b0;
      v_rad_q  <= 1'b0;
    end else if (en) begin
      v_prod_q <= in_valid_i;
      v_dot_q  <= v_prod_q;
      v_mag_q  <= v_dot_q;
      v_sq_q   <= v_mag_q;
      v_rad_q  <= v_sq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q       <= incident_x_i * normal_x_i;
      py_q       <= incident_y_i * normal_y_i;
      pz_q       <= incident_z_i * normal_z_i;
      dot_q      <= DOT_W'(px_q) + DOT_W'(py_q) + DOT_W'(pz_q);
      side_mag_q <= side_mag_d;
      sq_q       <= side_mag_q.mag * side_mag_q.mag;
      side_sq_q  <= side_mag_q;
      rad_q      <= ONE_Q60 - sq_q[RAD_W-1:0];
      side_rad_q <= side_sq_q;
    end
  end

  // incident sine
  logic [ROOT_W-1:0] sin_i;
  side_t             side_s1;

  fru_sqrt_pipe u_sqrt_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v_rad_q),
    .rad_i  (rad_q),
    .side_i (side_rad_q),
    .vld_o  (v_sqrt1),
    .root_o (sin_i),
    .side_o (side_s1)
  );

  // snell numerator sin_i * etai
  logic [SN_NUM_W-1:0] num_q;
  side_t               side_num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q      <= sin_i * side_s1.etai;
      side_num_q <= side_s1;
    end
  end

  logic [SN_Q_W-1:0] sin_t;
  side_t             side_sn;

  fru_snell_div u_snell (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v_num_q),
    .num_i  (num_q),
    .side_i (side_num_q),
    .vld_o  (v_snell),
    .quot_o (sin_t),
    .side_o (side_sn)
  );

  // 1 - sin_t^2
  logic [2*SN_Q_W-1:0] sq2_q;
  side_t               side_sq2_q;
  logic [RAD_W-1:0]    rad2_q;
  side_t               side_rad2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq2_q       <= sin_t * sin_t;
      side_sq2_q  <= side_sn;
      rad2_q      <= ONE_Q60 - RAD_W'(sq2_q);
      side_rad2_q <= side_sq2_q;
    end
  end

  logic [ROOT_W-1:0] cos_t;
  side_t             side_s2;

  fru_sqrt_pipe u_sqrt_cos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v_rad2_q),
    .rad_i  (rad2_q),
    .side_i (side_rad2_q),
    .vld_o  (v_sqrt2),
    .root_o (cos_t),
    .side_o (side_s2)
  );

  // amplitude terms
  logic [MAG_W+IDX_W-1:0] as_q, bs_q, ap_q, bp_q;
  logic                   tir_ab_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      as_q     <= side_s2.etat * side_s2.mag;
      bs_q     <= side_s2.etai * cos_t;
      ap_q     <= side_s2.etai * side_s2.mag;
      bp_q     <= side_s2.etat * cos_t;
      tir_ab_q <= side_s2.tir;
    end
  end

  // ratio numerators and denominators, zero denominator gives one
  logic [RR_NUM_W-1:0] nd_ns_d, nd_ds_d, nd_np_d, nd_dp_d;
  logic [RR_NUM_W-1:0] ns_q, ds_q, np_q, dp_q;
  logic                tir_nd_q;

  always_comb begin
    nd_ds_d = RR_NUM_W'(as_q) + RR_NUM_W'(bs_q);
    nd_ns_d = (as_q >= bs_q) ? RR_NUM_W'(as_q - bs_q) : RR_NUM_W'(bs_q - as_q);
    nd_dp_d = RR_NUM_W'(ap_q) + RR_NUM_W'(bp_q);
    nd_np_d = (ap_q >= bp_q) ? RR_NUM_W'(ap_q - bp_q) : RR_NUM_W'(bp_q - ap_q);
    if (nd_ds_d == '0) begin
      nd_ds_d = RR_NUM_W'(1);
      nd_ns_d = RR_NUM_W'(1);
    end
    if (nd_dp_d == '0) begin
      nd_dp_d = RR_NUM_W'(1);
      nd_np_d = RR_NUM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ns_q     <= nd_ns_d;
      ds_q     <= nd_ds_d;
      np_q     <= nd_np_d;
      dp_q     <= nd_dp_d;
      tir_nd_q <= tir_ab_q;
    end
  end

  logic [RR_Q_W-1:0] rs, rp;
  logic              tir_rr;

  fru_ratio_div u_ratio (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (v_nd_q),
    .num_s_i  (ns_q),
    .den_s_i  (ds_q),
    .num_p_i  (np_q),
    .den_p_i  (dp_q),
    .tir_i    (tir_nd_q),
    .vld_o    (v_ratio),
    .quot_s_o (rs),
    .quot_p_o (rp),
    .tir_o    (tir_rr)
  );

  // squared ratios
  logic [2*RR_Q_W-1:0] rs2_q, rp2_q;
  logic                tir_sq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rs2_q    <= rs * rs;
      rp2_q    <= rp * rp;
      tir_sq_q <= tir_rr;
    end
  end

  // average, round half up, saturate
  logic [2*RR_Q_W:0]  sum;
  logic [RR_Q_W-1:0]  r_rnd;
  logic [OUT_W-1:0]   refl_q;
  logic               tir_out_q;

  assign sum   = (2*RR_Q_W+1)'(rs2_q) + (2*RR_Q_W+1)'(rp2_q) + (2*RR_Q_W+1)'(1 << 17);
  assign r_rnd = RR_Q_W'(sum >> 18);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tir_out_q <= tir_sq_q;
      if (tir_sq_q || (r_rnd > RR_Q_W'(OUT_ONE))) begin
        refl_q <= OUT_ONE;
      end else begin
        refl_q <= r_rnd[OUT_W-1:0];
      end
    end
  end

  // valid bits of the back stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_num_q  <= 1'b0;
      v_sq2_q  <= 1'b0;
      v_rad2_q <= 1'b0;
      v_ab_q   <= 1'b0;
      v_nd_q   <= 1'b0;
      v_rsq_q  <= 1'b0;
      v_out_q  <= 1'b0;
    end else if (en) begin
      v_num_q  <= v_sqrt1;
      v_sq2_q  <= v_snell;
      v_rad2_q <= v_sq2_q;
      v_ab_q   <= v_sqrt2;
      v_nd_q   <= v_ab_q;
      v_rsq_q  <= v_ratio;
      v_out_q  <= v_rsq_q;
    end
  end

  assign out_valid_o      = v_out_q;
  assign reflectance_o    = refl_q;
  assign total_internal_o = tir_out_q;

`ifndef NO_ASSERTIONS
  a_tir_is_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && total_internal_o) |-> (reflectance_o == OUT_ONE))
    else $error("total internal reflection word without full reflectance");

  a_refl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reflectance_o <= OUT_ONE))
    else $error("reflectance above one");

  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  a_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !v_rsq_q) |=> !out_valid_o)
    else $error("output word appeared without a word in the last stage");
`endif

endmodule

>>> test/fresnel_reflectance_unit_tb.sv
// ----------------------------------------------------------------------------
// fresnel_reflectance_unit_tb
// Self-checking bench: drives incident/normal words through the valid/stall
// channel, predicts each reflectance in 64-bit fixed point and compares in order.
// ----------------------------------------------------------------------------
module fresnel_reflectance_unit_tb;
  import fru_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] refl;
    logic             tir;
  } fresnel_word_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [IDX_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [VEC_W-1:0] incident_x_i, incident_y_i, incident_z_i;
  logic signed [VEC_W-1:0] normal_x_i, normal_y_i, normal_z_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [OUT_W-1:0]        reflectance_o;
  logic                    total_internal_o;

  localparam int LATENCY   = 122;
  localparam int MAX_CYCLE = 400000;

  fresnel_word_t   pending_refl_q[$];
  logic [IDX_W-1:0] index_model;
  int send_idle_pct, recv_idle_pct;
  int hold_off_cycles;
  int n_errors, n_sent, n_checked, n_tir, cycle_count;

  fresnel_reflectance_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .incident_x_i(incident_x_i), .incident_y_i(incident_y_i),
    .incident_z_i(incident_z_i), .normal_x_i(normal_x_i),
    .normal_y_i(normal_y_i), .normal_z_i(normal_z_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .reflectance_o(reflectance_o), .total_internal_o(total_internal_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("fresnel_reflectance_unit verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] amp_ratio(logic [63:0] a, logic [63:0] b);
    logic [63:0] num, den;
    num = (a >= b) ? a - b : b - a;
    den = a + b;
    if (den == 0) return 64'd1 << 16;
    return (num << 16) / den;
  endfunction

  // expected reflectance for one word
  function automatic fresnel_word_t fresnel_predict(logic signed [VEC_W-1:0] v[6]);
    fresnel_word_t w;
    logic signed [63:0] dot;
    logic [63:0] mag, idx, etai, etat, sin_i, sin_t, cos_t, rs, rp, sum, r;
    dot = 0;
    for (int k = 0; k < 3; k++) dot += 64'(v[k]) * 64'(v[3+k]);
    mag = (dot < 0) ? 64'(-dot) : 64'(dot);
    if (2 * VEC_FRAC_BITS >= 30) mag = mag >> (2 * VEC_FRAC_BITS - 30);
    else mag = mag << (30 - 2 * VEC_FRAC_BITS);
    if (mag > (64'd1 << 30)) mag = 64'd1 << 30;
    idx  = (index_model != 0) ? 64'(index_model) : 64'd1;
    etai = (dot > 0) ? idx : 64'd4096;
    etat = (dot > 0) ? 64'd4096 : idx;
    sin_i = int_sqrt((64'd1 << 60) - mag * mag);
    sin_t = (sin_i * etai) / etat;
    if (sin_t >= (64'd1 << 30)) begin
      w.refl = OUT_ONE;
      w.tir  = 1'b1;
      return w;
    end
    cos_t = int_sqrt((64'd1 << 60) - sin_t * sin_t);
    rs  = amp_ratio(etat * mag, etai * cos_t);
    rp  = amp_ratio(etai * mag, etat * cos_t);
    sum = rs * rs + rp * rp;
    r   = (sum + (64'd1 << 17)) >> 18;
    if (r > 32768) r = 32768;
    w.refl = r[OUT_W-1:0];
    w.tir  = 1'b0;
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on word %0d: %s got %0d expected %0d", n_checked, what, got, want);
    n_errors++;
  endtask

  // send one word, recording its prediction when accepted
  task automatic send_word(logic signed [VEC_W-1:0] v[6]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    incident_x_i <= v[0];
    incident_y_i <= v[1];
    incident_z_i <= v[2];
    normal_x_i   <= v[3];
    normal_y_i   <= v[4];
    normal_z_i   <= v[5];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_refl_q.push_back(fresnel_predict(v));
    n_sent++;
  endtask

  // receiver stall, with optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall_i     <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    fresnel_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_refl_q.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        w = pending_refl_q.pop_front();
        if (reflectance_o !== w.refl) report_mismatch("reflectance", reflectance_o, w.refl);
        if (total_internal_o !== w.tir) report_mismatch("total_internal", total_internal_o, w.tir);
        if (w.tir) n_tir++;
      end
      n_checked++;
    end
  end

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_refl_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic set_index(logic [IDX_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    index_model = value;
  endtask

  function automatic logic signed [VEC_W-1:0] rand_comp(bit full);
    if (full) return VEC_W'($urandom);
    return VEC_W'($signed($urandom_range(32768)) - 16384);
  endfunction

  // random unit-ish vector pair, mostly near unit length
  task automatic send_random(bit noisy);
    logic signed [VEC_W-1:0] v[6];
    real a, b, c, n;
    for (int s = 0; s < 2; s++) begin
      a = $itor($signed($urandom_range(2000)) - 1000);
      b = $itor($signed($urandom_range(2000)) - 1000);
      c = $itor($signed($urandom_range(2000)) - 1000);
      n = $sqrt(a * a + b * b + c * c);
      if (n < 1.0) begin a = 1000.0; n = 1000.0; end
      v[3*s]   = VEC_W'($rtoi(a / n * 16384.0));
      v[3*s+1] = VEC_W'($rtoi(b / n * 16384.0));
      v[3*s+2] = VEC_W'($rtoi(c / n * 16384.0));
    end
    if (noisy) for (int k = 0; k < 6; k++) v[k] = rand_comp($urandom_range(1));
    send_word(v);
  endtask

  task automatic test_directed;
    logic signed [VEC_W-1:0] v[6];
    logic signed [VEC_W-1:0] ext[5] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sh7fff, 16'sh8000};
    // extremes from the list, each paired with the next one
    for (int k = 0; k < 5; k++) begin
      v = '{ext[k], 0, 0, ext[(k+1)%5], 0, 0};
      send_word(v);
    end
    // grazing incidence
    v = '{16384, 0, 0, 0, 16384, 0};       send_word(v);
    // normal entry and normal exit
    v = '{0, 0, -16384, 0, 0, 16384};      send_word(v);
    v = '{0, 0, 16384, 0, 0, 16384};       send_word(v);
    // oblique exit with total internal reflection, then oblique entry
    v = '{11585, 0, 11585, 0, 0, 16384};   send_word(v);
    v = '{-11585, 0, -11585, 0, 0, 16384}; send_word(v);
    // oversized vectors with clamped dot product, then tiny and zero vectors
    v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}; send_word(v);
    v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff}; send_word(v);
    v = '{-1, -1, -1, -1, -1, -1};          send_word(v);
    v = '{0, 0, 0, 0, 0, 0};                send_word(v);
  endtask

  task automatic test_index_sweep;
    logic [IDX_W-1:0] idx_set[6] = '{14'd0, 14'd1, 14'd2048, 14'd4096, 14'd16383, 14'd6144};
    foreach (idx_set[i]) begin
      set_index(idx_set[i]);
      for (int k = 0; k < 20; k++) send_random(k % 4 == 0);
    end
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0) set_index(IDX_W'($urandom_range(16383)));
      send_random($urandom_range(9) == 0);
    end
  endtask

  // long receiver hold-off while the sender keeps offering words
  task automatic test_backpressure;
    drain();
    hold_off_cycles = 300;
    for (int k = 0; k < 200; k++) send_random(1'b0);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_wdata_i = '0; in_valid_i = 1'b0;
    incident_x_i = '0; incident_y_i = '0; incident_z_i = '0;
    normal_x_i = '0; normal_y_i = '0; normal_z_i = '0;
    out_stall_i = 1'b0; hold_off_cycles = 0; cycle_count = 0;
    n_errors = 0; n_sent = 0; n_checked = 0; n_tir = 0;
    index_model = IDX_RESET;
    send_idle_pct = 37; recv_idle_pct = 54;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_index_sweep();
    test_random(200);
    send_idle_pct = 54; recv_idle_pct = 37;
    test_random(200);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(150);
    test_backpressure();
    drain();
    $display("sent %0d words, checked %0d results (%0d total internal reflection)",
             n_sent, n_checked, n_tir);
    $display("covered index extremes, grazing/normal/clamped vectors and long back-pressure");
    if (n_errors == 0) begin
      $display("fresnel_reflectance_unit verification clean");
    end else begin
      $display("fresnel_reflectance_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fru_pkg.sv
rtl/fru_sqrt_pipe.sv
rtl/fru_snell_div.sv
rtl/fru_ratio_div.sv
rtl/fresnel_reflectance_unit.sv
test/fresnel_reflectance_unit_tb.sv
